FILE: design/eed_pkg.sv
// Shared types, constants and helper functions for the echo escape decoder.
`default_nettype none

package eed_pkg;

  localparam int unsigned RUN_BYTES  = 4;
  localparam int unsigned RUN_CNT_W  = $clog2(RUN_BYTES + 1);
  localparam int unsigned FIFO_DEPTH = 2;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPES_ON = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWLINE_ON = 8'd1;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_V   = 8'h76;
  localparam logic [7:0] CH_LC_E   = 8'h65;
  localparam logic [7:0] CH_LC_C   = 8'h63;
  localparam logic [7:0] CH_LC_X   = 8'h78;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_F   = 8'h46;

  localparam logic [1:0] OCT_DIGITS = 2'd3;
  localparam logic [1:0] HEX_DIGITS = 2'd2;

  typedef enum logic [1:0] {
    MODE_PLAIN  = 2'd0,
    MODE_BSLASH = 2'd1,
    MODE_OCTAL  = 2'd2,
    MODE_HEX    = 2'd3
  } mode_e;

  // Bytes caused by one input item, packed from index 0
  typedef struct packed {
    logic [RUN_BYTES-1:0][7:0] bytes;
    logic [RUN_CNT_W-1:0]      cnt;
  } run_t;

  function automatic run_t run_push(run_t r, logic [7:0] b);
    run_t o;
    o = r;
    if (r.cnt < RUN_CNT_W'(RUN_BYTES)) begin
      o.bytes[r.cnt[$clog2(RUN_BYTES)-1:0]] = b;
      o.cnt = r.cnt + RUN_CNT_W'(1);
    end
    return o;
  endfunction

  // {is_digit, value}
  function automatic logic [4:0] hex_val(logic [7:0] b);
    logic [4:0] o;
    o = 5'd0;
    if (b >= CH_ZERO && b <= CH_NINE)
      o = {1'b1, 4'(b - CH_ZERO)};
    else if (b >= CH_LC_A && b <= CH_LC_F)
      o = {1'b1, 4'(b - CH_LC_A + 8'd10)};
    else if (b >= CH_UC_A && b <= CH_UC_F)
      o = {1'b1, 4'(b - CH_UC_A + 8'd10)};
    return o;
  endfunction

  // Closes a pending number escape; \x without digits comes out literally
  function automatic run_t fin_number(run_t r, mode_e m, logic [1:0] c, logic [7:0] v);
    run_t o;
    o = r;
    if (m == MODE_HEX && c == 2'd0) begin
      o = run_push(o, CH_BSLASH);
      o = run_push(o, CH_LC_X);
    end else begin
      o = run_push(o, v);
    end
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: design/eed_if.sv
// Channel interfaces of the echo escape decoder: input items, output bytes, configuration.
`default_nettype none

interface eed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       arg_end;
  logic       list_end;

  modport source (output valid, data_byte, byte_valid, arg_end, list_end, input ready);
  modport sink   (input valid, data_byte, byte_valid, arg_end, list_end, output ready);
endinterface

interface eed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, out_byte, run_last, input ready);
  modport sink   (input valid, out_byte, run_last, output ready);
endinterface

interface eed_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [eed_pkg::CFG_IDX_W-1:0]   index;
  logic [eed_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: design/eed_front.sv
// Front end: accepts items, runs the escape state machine and builds result runs.
`default_nettype none

module eed_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  eed_in_if.sink           in_i,
  eed_cfg_if.sink          cfg_i,
  input  wire logic        full_i,
  output eed_pkg::run_t    push_run_o,
  output logic             push_o
);

  eed_pkg::mode_e mode_q, mode_d;
  logic [1:0]     cnt_q, cnt_d;
  logic [7:0]     val_q, val_d;
  logic           stop_q, stop_d;
  logic           esc_on_q, nl_on_q;
  eed_pkg::run_t  run;
  logic           accept;

  assign in_i.ready  = !full_i;
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;
  assign push_o      = accept && (run.cnt != '0);
  assign push_run_o  = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_on_q <= 1'b0;
      nl_on_q  <= 1'b1;
    end else if (cfg_i.valid && cfg_i.ready) begin
      if (cfg_i.index == eed_pkg::CFG_ESCAPES_ON) esc_on_q <= cfg_i.data[0];
      if (cfg_i.index == eed_pkg::CFG_NEWLINE_ON) nl_on_q  <= cfg_i.data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= eed_pkg::MODE_PLAIN;
      cnt_q  <= 2'd0;
      val_q  <= 8'd0;
      stop_q <= 1'b0;
    end else if (accept) begin
      mode_q <= mode_d;
      cnt_q  <= cnt_d;
      val_q  <= val_d;
      stop_q <= stop_d;
    end
  end

  always_comb begin
    logic [7:0] b;
    logic [4:0] hv;
    logic       do_fin;
    logic       do_plain;
    b        = in_i.data_byte;
    hv       = eed_pkg::hex_val(b);
    do_fin   = 1'b0;
    do_plain = 1'b0;
    run      = '0;
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    val_d    = val_q;
    stop_d   = stop_q;

    // byte first
    if (in_i.byte_valid && !stop_d) begin
      unique case (mode_d)
        eed_pkg::MODE_PLAIN: do_plain = 1'b1;
        eed_pkg::MODE_BSLASH: begin
          mode_d = eed_pkg::MODE_PLAIN;
          unique case (b)
            eed_pkg::CH_LC_N:   run = eed_pkg::run_push(run, eed_pkg::CH_NL);
            eed_pkg::CH_LC_T:   run = eed_pkg::run_push(run, eed_pkg::CH_TAB);
            eed_pkg::CH_LC_R:   run = eed_pkg::run_push(run, eed_pkg::CH_CR);
            eed_pkg::CH_BSLASH: run = eed_pkg::run_push(run, eed_pkg::CH_BSLASH);
            eed_pkg::CH_LC_A:   run = eed_pkg::run_push(run, eed_pkg::CH_BEL);
            eed_pkg::CH_LC_B:   run = eed_pkg::run_push(run, eed_pkg::CH_BS);
            eed_pkg::CH_LC_F:   run = eed_pkg::run_push(run, eed_pkg::CH_FF);
            eed_pkg::CH_LC_V:   run = eed_pkg::run_push(run, eed_pkg::CH_VT);
            eed_pkg::CH_LC_E:   run = eed_pkg::run_push(run, eed_pkg::CH_ESC);
            eed_pkg::CH_LC_C:   stop_d = 1'b1;
            eed_pkg::CH_ZERO: begin
              mode_d = eed_pkg::MODE_OCTAL;
              cnt_d  = 2'd0;
              val_d  = 8'd0;
            end
            eed_pkg::CH_LC_X: begin
              mode_d = eed_pkg::MODE_HEX;
              cnt_d  = 2'd0;
              val_d  = 8'd0;
            end
            default: begin
              // unknown escape goes out as written
              run = eed_pkg::run_push(run, eed_pkg::CH_BSLASH);
              run = eed_pkg::run_push(run, b);
            end
          endcase
        end
        eed_pkg::MODE_OCTAL: begin
          if (b >= eed_pkg::CH_ZERO && b <= eed_pkg::CH_SEVEN &&
              cnt_d < eed_pkg::OCT_DIGITS) begin
            val_d  = {val_d[4:0], b[2:0]};
            cnt_d  = cnt_d + 2'd1;
            do_fin = (cnt_d == eed_pkg::OCT_DIGITS);
          end else begin
            do_fin   = 1'b1;
            do_plain = 1'b1;
          end
        end
        eed_pkg::MODE_HEX: begin
          if (hv[4] && cnt_d < eed_pkg::HEX_DIGITS) begin
            val_d  = {val_d[3:0], hv[3:0]};
            cnt_d  = cnt_d + 2'd1;
            do_fin = (cnt_d == eed_pkg::HEX_DIGITS);
          end else begin
            do_fin   = 1'b1;
            do_plain = 1'b1;
          end
        end
        default: ;
      endcase

      if (do_fin) begin
        run    = eed_pkg::fin_number(run, mode_d, cnt_d, val_d);
        mode_d = eed_pkg::MODE_PLAIN;
        cnt_d  = 2'd0;
        val_d  = 8'd0;
      end
      if (do_plain) begin
        if (esc_on_q && b == eed_pkg::CH_BSLASH) mode_d = eed_pkg::MODE_BSLASH;
        else run = eed_pkg::run_push(run, b);
      end
    end

    // argument end; list end counts as one
    if ((in_i.arg_end || in_i.list_end) && !stop_d) begin
      if (mode_d == eed_pkg::MODE_BSLASH) begin
        run    = eed_pkg::run_push(run, eed_pkg::CH_BSLASH);
        mode_d = eed_pkg::MODE_PLAIN;
      end else if (mode_d != eed_pkg::MODE_PLAIN) begin
        run    = eed_pkg::fin_number(run, mode_d, cnt_d, val_d);
        mode_d = eed_pkg::MODE_PLAIN;
        cnt_d  = 2'd0;
        val_d  = 8'd0;
      end
      if (!in_i.list_end) run = eed_pkg::run_push(run, eed_pkg::CH_SPACE);
    end

    if (in_i.list_end) begin
      if (nl_on_q && !stop_d) run = eed_pkg::run_push(run, eed_pkg::CH_NL);
      stop_d = 1'b0;
      mode_d = eed_pkg::MODE_PLAIN;
      cnt_d  = 2'd0;
      val_d  = 8'd0;
    end
  end

endmodule

`default_nettype wire

FILE: design/eed_fifo.sv
// Short queue of result runs between front end and back end.
`default_nettype none

module eed_fifo (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  push_i,
  input  wire eed_pkg::run_t         push_run_i,
  input  wire logic                  pop_i,
  output eed_pkg::run_t              head_o,
  output logic                       full_o,
  output logic                       empty_o
);

  eed_pkg::run_t                        mem_q [eed_pkg::FIFO_DEPTH];
  logic [eed_pkg::FIFO_PTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [eed_pkg::FIFO_CNT_W-1:0]       cnt_q;

  assign full_o  = (cnt_q == eed_pkg::FIFO_CNT_W'(eed_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_run_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + eed_pkg::FIFO_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + eed_pkg::FIFO_PTR_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + eed_pkg::FIFO_CNT_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - eed_pkg::FIFO_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/eed_back.sv
// Back end: sends the bytes of the head run one per transfer, marking the last.
`default_nettype none

module eed_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire eed_pkg::run_t head_i,
  input  wire logic          empty_i,
  output logic               pop_o,
  eed_out_if.source          out_o
);

  logic [$clog2(eed_pkg::RUN_BYTES)-1:0] idx_q;
  logic                                  last;

  assign last           = ({1'b0, idx_q} == head_i.cnt - eed_pkg::RUN_CNT_W'(1));
  assign out_o.valid    = !empty_i;
  assign out_o.out_byte = head_i.bytes[idx_q];
  assign out_o.run_last = last;
  assign pop_o          = out_o.valid && out_o.ready && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (out_o.valid && out_o.ready) begin
      if (last) idx_q <= '0;
      else      idx_q <= idx_q + 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: design/echo_escape_decoder.sv
// Top level of the echo escape decoder: front end, run queue and back end.
//
//  channel | dir | payload                                   | transfer when
//  --------+-----+-------------------------------------------+----------------
//  in_i    | in  | data_byte[8] byte_valid arg_end list_end  | valid && ready
//  out_o   | out | out_byte[8] run_last                      | valid && ready
//  cfg_i   | in  | index[8] data[8] (bit 0 used)             | valid && ready
//
// An item is decoded in the cycle it is taken; its run of up to 4 bytes, if not empty,
// enters a two-entry queue and leaves one byte per cycle while the output is ready.
// Input rate is one item per cycle while each item yields at most one byte and out_o is
// ready; longer runs hold the input back once the queue fills.
// Any item, even one that yields nothing, waits while the queue is full.
// Reset clears the escape state and the queue; escapes_on resets to 0, newline_on to 1.
`default_nettype none

module echo_escape_decoder (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  eed_in_if.sink    in_i,
  eed_out_if.source out_o,
  eed_cfg_if.sink   cfg_i
);

  eed_pkg::run_t push_run, head;
  logic          push, pop, full, empty;

  eed_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cfg_i      (cfg_i),
    .full_i     (full),
    .push_run_o (push_run),
    .push_o     (push)
  );

  eed_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_run_i (push_run),
    .pop_i      (pop),
    .head_o     (head),
    .full_o     (full),
    .empty_o    (empty)
  );

  eed_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire

FILE: design/eed_checker.sv
// Port-level checker for the echo escape decoder, bound to the top level.
`default_nettype none

module eed_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       run_last_i,
  input wire logic       cfg_ready_i
);

  // stalled output keeps its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(run_last_i))
    else $error("output changed while stalled");

  // input only backs up when the output has something waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with output idle");

  // no output appears without an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i && !(in_valid_i && in_ready_i) |=> !out_valid_i)
    else $error("output appeared without an input transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_i)
    else $error("configuration port not ready");

endmodule

bind echo_escape_decoder eed_checker u_eed_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_byte_i  (out_o.out_byte),
  .run_last_i  (out_o.run_last),
  .cfg_ready_i (cfg_i.ready)
);

`default_nettype wire
